### design/btds_pkg.sv
// Shared constants and types for the byte translate/delete/squeeze filter.
// No dependencies; imported by the top level.
package btds_pkg;

   localparam int BYTE_W      = 8;
   localparam int TABLE_DEPTH = 256;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   // Kind of an input item
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   // Register index, taken from the word address of the CSR port
   typedef enum logic [2:0] {
      REG_DELETE     = 3'd0,
      REG_COMPLEMENT = 3'd1,
      REG_SQUEEZE    = 3'd2,
      REG_TRANSLATE  = 3'd3,
      REG_FILL       = 3'd4
   } csr_index_type;

   // Mode registers as seen by the datapath
   typedef struct packed {
      logic              delete_mode;
      logic              complement_mode;
      logic              squeeze_mode;
      logic              translate_enable;
      logic [BYTE_W-1:0] fill_byte;
   } mode_type;

   // One entry of the first-set / translate table
   typedef struct packed {
      logic              in_first;
      logic [BYTE_W-1:0] mapped;
   } map_entry_type;

   localparam int MAP_ENTRY_W = $bits(map_entry_type);

endpackage

### design/byte_translate_delete_squeeze_top.sv
// Top level of the byte translate/delete/squeeze filter.
// Depends on btds_pkg and btds_ram.
//
// Streams bytes through a tr-style filter at one item per clock cycle. Each
// req item is either a table load (kind 1), which writes the first-set flag,
// squeeze-set flag and mapped byte for one byte value and returns nothing,
// or a data byte (kind 0), which returns zero or one rsp item. A data byte
// reads the first-set/translate RAM at the byte, then the squeeze RAM at the
// candidate output byte, then its result is registered. The two RAM read
// ports set this pipeline. The whole pipeline advances when the rsp register
// is empty or being taken, so req_ready follows rsp_ready. Table entries
// never loaded read as their reset value through per-entry valid bits, so
// no clearing pass follows reset. Mode registers are to be written through
// the APB port while the filter is idle; the block itself does not enforce
// this. Reads return the register values.
module byte_translate_delete_squeeze_top
   import btds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  logic                  req_load_in_first,
   input  logic                  req_load_in_squeeze,
   input  logic [BYTE_W-1:0]     req_load_mapped,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   mode_type      mode_ff, mode_in;
   csr_index_type csr_index;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write) begin
         case (csr_index)
            REG_DELETE:     mode_in.delete_mode      = pwdata[0];
            REG_COMPLEMENT: mode_in.complement_mode  = pwdata[0];
            REG_SQUEEZE:    mode_in.squeeze_mode     = pwdata[0];
            REG_TRANSLATE:  mode_in.translate_enable = pwdata[0];
            REG_FILL:       mode_in.fill_byte        = pwdata[BYTE_W-1:0];
            default:        mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         REG_DELETE:     prdata = CSR_DATA_W'(mode_ff.delete_mode);
         REG_COMPLEMENT: prdata = CSR_DATA_W'(mode_ff.complement_mode);
         REG_SQUEEZE:    prdata = CSR_DATA_W'(mode_ff.squeeze_mode);
         REG_TRANSLATE:  prdata = CSR_DATA_W'(mode_ff.translate_enable);
         REG_FILL:       prdata = CSR_DATA_W'(mode_ff.fill_byte);
         default:        prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Pipeline control
   // ---------------------------------------------------------------
   logic advance;
   logic req_fire;
   logic load_fire;
   logic out_valid_ff, out_valid_in;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign req_fire  = req_valid && req_ready;
   assign load_fire = req_fire && (req_kind == KIND_LOAD);

   // ---------------------------------------------------------------
   // Table storage: loads write both RAMs and set the entry valid bit
   // ---------------------------------------------------------------
   logic [TABLE_DEPTH-1:0] entry_valid_ff;
   map_entry_type          map_wr_data;
   map_entry_type          map_rd_data;
   logic                   sq_rd_data;
   logic [BYTE_W-1:0]      cand_byte;

   assign map_wr_data.in_first = req_load_in_first;
   assign map_wr_data.mapped   = req_load_mapped;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (load_fire) begin
         entry_valid_ff[req_byte_value] <= 1'b1;
      end
   end

   btds_ram #(
      .WIDTH (MAP_ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (req_byte_value),
      .wr_data (map_wr_data),
      .rd_en   (advance),
      .rd_addr (req_byte_value),
      .rd_data (map_rd_data)
   );

   btds_ram #(
      .WIDTH (1),
      .DEPTH (TABLE_DEPTH)
   ) u_squeeze_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (req_byte_value),
      .wr_data (req_load_in_squeeze),
      .rd_en   (advance),
      .rd_addr (cand_byte[ADDR_W-1:0]),
      .rd_data (sq_rd_data)
   );

   // ---------------------------------------------------------------
   // Stage 1: first-set lookup, delete and translate
   // ---------------------------------------------------------------
   logic              st1_valid_ff;
   logic [BYTE_W-1:0] st1_byte_ff;
   logic              st1_entry_ok_ff;
   logic              member;
   logic [BYTE_W-1:0] mapped;
   logic              drop;

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
      end else if (advance) begin
         st1_valid_ff <= req_fire && (req_kind == KIND_DATA);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_byte_ff     <= req_byte_value;
         st1_entry_ok_ff <= entry_valid_ff[req_byte_value];
      end
   end

   // unloaded entries: not a member, identity mapping
   assign member = st1_entry_ok_ff && map_rd_data.in_first;
   assign mapped = st1_entry_ok_ff ? map_rd_data.mapped : st1_byte_ff;
   assign drop   = mode_ff.delete_mode && (member != mode_ff.complement_mode);

   always_comb begin
      cand_byte = st1_byte_ff;
      if (!mode_ff.delete_mode && mode_ff.translate_enable) begin
         if (mode_ff.complement_mode) begin
            if (!member) begin
               cand_byte = mode_ff.fill_byte;
            end
         end else if (member) begin
            cand_byte = mapped;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: squeeze test against the last candidate byte
   // ---------------------------------------------------------------
   logic              st2_valid_ff;
   logic [BYTE_W-1:0] st2_byte_ff;
   logic              st2_entry_ok_ff;
   logic              last_valid_ff;
   logic [BYTE_W-1:0] last_byte_ff;
   logic              in_squeeze;
   logic              squeeze_hit;
   logic [BYTE_W-1:0] out_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_valid_ff <= 1'b0;
      end else if (advance) begin
         st2_valid_ff <= st1_valid_ff && !drop;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st2_byte_ff     <= cand_byte;
         st2_entry_ok_ff <= entry_valid_ff[cand_byte];
      end
   end

   // inverted set test for complement without a second set
   assign in_squeeze  = (st2_entry_ok_ff && sq_rd_data)
                        ^ (!mode_ff.translate_enable && mode_ff.complement_mode);
   assign squeeze_hit = mode_ff.squeeze_mode && last_valid_ff
                        && (last_byte_ff == st2_byte_ff) && in_squeeze;

   // history moves with every candidate byte, squeezed or not
   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
         last_byte_ff  <= '0;
      end else if (advance && st2_valid_ff) begin
         last_valid_ff <= 1'b1;
         last_byte_ff  <= st2_byte_ff;
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   assign out_valid_in = advance ? (st2_valid_ff && !squeeze_hit) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff <= st2_byte_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> (entry_valid_ff == '0))
      else $error("entry valid bits not cleared by reset");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load_fire |=> entry_valid_ff[$past(req_byte_value)])
      else $error("table load did not mark its entry valid");

   a_result_from_stage2: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(st2_valid_ff))
      else $error("result item without a data item in stage 2");

   a_stall_holds_history: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(last_byte_ff) && $stable(last_valid_ff)))
      else $error("squeeze history changed during a stall");

endmodule

### design/btds_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read returns the old contents when the same entry is written in that cycle.
module btds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
